// ===== design/assert_macros.svh =====
// Assertion macros shared by the hash block RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, checked every clock outside reset.
`define C31H_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: name");

// Condition that must never be true outside reset.
`define C31H_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: name");

`else

`define C31H_ASSERT(name, clk, rst_n, prop)
`define C31H_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== design/c31h_pkg.sv =====
// Shared types, constants and the CRC table function of the string hash block.
// No dependencies.
`default_nettype none

package c31h_pkg;

    localparam int HASH_W       = 31;
    localparam int CHAR_W       = 8;
    localparam int IDX_W        = 7;
    localparam int BUCKET_W     = 14;
    localparam int BUCKET_CNT_W = 17;   // holds bucket counts up to 65536

    localparam int BUCKET_COUNT_DEF = 13309;

    localparam logic [HASH_W-1:0] POLY_WORD = 31'h4800_0000;

    // Hash queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef logic [HASH_W-1:0]   hash_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [BUCKET_W-1:0] bucket_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Table word: XOR of POLY_WORD >> j over each set bit j of the index.
    function automatic hash_t table_word(input logic [IDX_W-1:0] idx);
        hash_t acc;
        acc = '0;
        for (int j = 0; j < IDX_W; j++) begin
            if (idx[j]) begin
                acc = acc ^ (POLY_WORD >> j);
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== design/c31h_front.sv =====
// Front part: takes characters, folds them into the running hash and
// pushes the finished hash of each name. Depends on c31h_pkg.
`default_nettype none

module c31h_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire c31h_pkg::char_t       s_character,
    input  wire logic                  s_last_char,
    input  wire c31h_pkg::q_status_t   q_status,
    output logic                       push,
    output c31h_pkg::hash_t            push_hash
);
    import c31h_pkg::*;

    hash_t hash_reg;
    hash_t hash_next;
    hash_t folded;
    logic  take;

    assign s_ready = !q_status.full;
    assign take    = s_valid && s_ready;

    // One fold step: shift by 7, XOR the table word
    assign folded = (hash_reg >> IDX_W)
                  ^ table_word(hash_reg[IDX_W-1:0] ^ s_character[IDX_W-1:0]);

    always_comb begin
        hash_next = hash_reg;
        if (take) begin
            hash_next = s_last_char ? '0 : folded;
        end
    end

    assign push      = take && s_last_char;
    assign push_hash = folded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/c31h_queue.sv =====
// Short FIFO of finished hashes between the front and back parts.
// Depends on c31h_pkg and assert_macros.svh.
`default_nettype none

module c31h_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire c31h_pkg::hash_t       push_hash,
    input  wire logic                  pop,
    output c31h_pkg::hash_t            head_hash,
    output c31h_pkg::q_status_t        q_status
);
    import c31h_pkg::*;

    hash_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_hash      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_hash;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "assert_macros.svh"

    `C31H_NEVER(a_q_overflow, aclk, aresetn, push && q_status.full)
    `C31H_NEVER(a_q_underflow, aclk, aresetn, pop && q_status.empty)
    `C31H_ASSERT(a_q_count_ok, aclk, aresetn, count_reg <= QCNT_W'(QDEPTH))
    `C31H_ASSERT(a_q_ptr_gap, aclk, aresetn, (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]))

endmodule

`default_nettype wire

// ===== design/c31h_back.sv =====
// Back part: bucket index by reciprocal multiply, one correction step,
// and the output register. Depends on c31h_pkg and assert_macros.svh.
`default_nettype none

module c31h_back #(
    parameter int BUCKET_COUNT = c31h_pkg::BUCKET_COUNT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire c31h_pkg::q_status_t   q_status,
    input  wire c31h_pkg::hash_t       head_hash,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output c31h_pkg::hash_t            m_hash_value,
    output c31h_pkg::bucket_t          m_bucket_index
);
    import c31h_pkg::*;

    // floor(2^31 / B): quotient estimate is at most one short
    localparam logic [HASH_W-1:0] RECIP =
        HASH_W'((64'd1 << HASH_W) / BUCKET_COUNT);
    localparam logic [BUCKET_CNT_W-1:0] BCNT = BUCKET_CNT_W'(BUCKET_COUNT);
    localparam logic [HASH_W:0]         BCNT_X = (HASH_W+1)'(BUCKET_COUNT);

    localparam int PROD_W = 2 * HASH_W;
    localparam int QB_W   = HASH_W + BUCKET_CNT_W;

    logic              adv;

    // stage 1: hash times reciprocal
    logic              v1_reg, v1_next;
    hash_t             h1_reg;
    logic [PROD_W-1:0] prod_reg;

    // stage 2: quotient estimate times bucket count
    logic              v2_reg, v2_next;
    hash_t             h2_reg;
    logic [QB_W-1:0]   qb_full;
    logic [HASH_W:0]   qb_reg;

    // stage 3: subtract, correct, output register
    logic              vo_reg, vo_next;
    hash_t             ho_reg;
    bucket_t           bo_reg;
    logic [HASH_W:0]   rem_raw;
    logic [HASH_W:0]   rem_fix;

    assign adv = !vo_reg || m_ready;
    assign pop = adv && !q_status.empty;

    assign qb_full = prod_reg[PROD_W-1:HASH_W] * BCNT;
    assign rem_raw = {1'b0, h2_reg} - qb_reg;
    assign rem_fix = (rem_raw >= BCNT_X) ? rem_raw - BCNT_X : rem_raw;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        vo_next = vo_reg;
        if (adv) begin
            v1_next = pop;
            v2_next = v1_reg;
            vo_next = v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h1_reg   <= head_hash;
            prod_reg <= head_hash * RECIP;
            h2_reg   <= h1_reg;
            qb_reg   <= qb_full[HASH_W:0];
            ho_reg   <= h2_reg;
            bo_reg   <= rem_fix[BUCKET_W-1:0];
        end
    end

    assign m_valid        = vo_reg;
    assign m_hash_value   = ho_reg;
    assign m_bucket_index = bo_reg;

`include "assert_macros.svh"

    // one correction must suffice: raw remainder below twice the count
    `C31H_ASSERT(a_rem_one_fix, aclk, aresetn, !v2_reg || (rem_raw < (BCNT_X << 1)))
    `C31H_ASSERT(a_bucket_range, aclk, aresetn, !m_valid || (BUCKET_COUNT > (1 << BUCKET_W)) || ({1'b0, m_bucket_index} < (BUCKET_W+1)'(BUCKET_COUNT)))
    `C31H_ASSERT(a_stall_keeps, aclk, aresetn, (v1_reg && !adv) |=> v1_reg)
    `C31H_ASSERT(a_no_pop_stall, aclk, aresetn, (vo_reg && !m_ready) |-> !pop)

endmodule

`default_nettype wire

// ===== design/crc31_string_hash_bucket_core.sv =====
// Top level of the table-driven 31-bit CRC string hash with bucket index.
// Depends on c31h_pkg, c31h_front, c31h_queue and c31h_back.
`default_nettype none

// Names arrive one character per transfer on the s_ channel, with
// s_last_char high on the final character. The block takes one character
// every cycle while the queue is not full; that rate is set by the fold
// recurrence in the front part, which forms the next 31-bit running hash
// in combinational logic (shift right by 7, XOR with a 128-entry table
// word held as constant logic). When a name ends, its hash goes into a
// four-entry queue and the running hash clears to zero for the next name.
// The back part pulls one hash per cycle unless its output is stalled and
// forms hash modulo BUCKET_COUNT through a reciprocal multiply, a multiply
// by the bucket count and one subtract-and-correct step. A finished hash
// passes the queue, the stage 1 and stage 2 registers and the output
// register before m_valid rises; a stalled m_ side or earlier queued names
// delay it further. With the result side stalled, the back pipeline holds,
// the queue fills, and s_ready drops only when all four queue slots are taken.
// No clearing pass is needed after reset. BUCKET_COUNT may range from 2 to
// 65536; above 16384 the bucket index is the remainder cut to 14 bits.

module crc31_string_hash_bucket_core #(
    parameter int BUCKET_COUNT = c31h_pkg::BUCKET_COUNT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // character transfers
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire c31h_pkg::char_t       s_character,
    input  wire logic                  s_last_char,
    // result transfers
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output c31h_pkg::hash_t            m_hash_value,
    output c31h_pkg::bucket_t          m_bucket_index
);
    import c31h_pkg::*;

    q_status_t q_status;
    logic      push;
    hash_t     push_hash;
    logic      pop;
    hash_t     head_hash;

    // Front: fold characters, push each finished name hash
    c31h_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last_char (s_last_char),
        .q_status    (q_status),
        .push        (push),
        .push_hash   (push_hash)
    );

    // Decoupling queue: lets the front keep taking characters while a
    // result waits on the m_ side
    c31h_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_hash (push_hash),
        .pop       (pop),
        .head_hash (head_hash),
        .q_status  (q_status)
    );

    // Back: bucket index pipeline and output register
    c31h_back #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_status       (q_status),
        .head_hash      (head_hash),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .m_bucket_index (m_bucket_index)
    );

endmodule

`default_nettype wire
